>>> src/mlfs_pkg.sv
package mlfs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int LEVELS    = 4;
  localparam int NPID      = 16;
  localparam int LVL_W     = 2;
  localparam int PID_W     = 4;
  localparam int RES_W     = 8;
  localparam int Q_W       = 8;
  localparam int ST_W      = 2;
  localparam int MV_W      = 5;
  localparam int FUNC_W    = 3;
  localparam int PTR_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int BLK_W     = PID_W + RES_W;

  localparam logic [FUNC_W-1:0] FN_ENQ    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SEL    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BLK    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNB    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REL    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SETLVL = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BEMPTY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEL_WB,
    S_UNB_WB,
    S_REL_WB,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_LATCH,
    STEP_EXEC,
    STEP_SEL_WB,
    STEP_UNB_WB,
    STEP_REL_WB,
    STEP_LOAD
  } step_e;

  typedef struct packed {
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              any_ready;
    logic              blk_empty;
    logic              rem_last;
    logic              out_free;
  } status_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(MAX_PROCS - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

>>> src/multilevel_feedback_scheduler.sv
// Four-level feedback scheduler with per-process levels, four ready queues
// and one blocked queue of (pid, resource) pairs.
// Request channel: in_valid_i/in_ready_o carrying func_i, pid_i, level_i and
// resource_i. Every request yields exactly one result on the response
// channel out_valid_o/out_ready_i (out_pid_o, quantum_o, status_o,
// moved_count_o).
// Quantum registers are written through cfg_valid_i/cfg_index_i/cfg_data_i;
// cfg_ready_o is always high and a write takes effect at once.
// After acceptance each request takes an execute step; select and unblock, when they
// find an entry, then take a write-back step, and release walks every blocked entry,
// one per cycle through the single read port of the blocked queue memory, before
// the result is loaded into the output register.
// A new request can be accepted from the cycle after the previous result is loaded
// into the output register, so the result may still wait there while the
// next request is being worked on.
// If the receiver stalls, the result holds in the output register and the
// next finished result waits in the datapath until that register frees.
// Reset (rst_ni low, asynchronous) empties all queues, sets every process to
// level 0 and restores the default quanta 1, 2, 4 and 8.
module multilevel_feedback_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mlfs_pkg::FUNC_W-1:0] func_i,
  input  logic [mlfs_pkg::PID_W-1:0]  pid_i,
  input  logic [mlfs_pkg::LVL_W-1:0]  level_i,
  input  logic [mlfs_pkg::RES_W-1:0]  resource_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mlfs_pkg::PID_W-1:0]  out_pid_o,
  output logic [mlfs_pkg::Q_W-1:0]    quantum_o,
  output logic [mlfs_pkg::ST_W-1:0]   status_o,
  output logic [mlfs_pkg::MV_W-1:0]   moved_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mlfs_pkg::Q_W-1:0]    cfg_data_i
);

  // The controller only sequences; all queue state lives in the datapath.
  mlfs_pkg::cmd_t    cmd;
  mlfs_pkg::status_t sts;

  assign cfg_ready_o = 1'b1;

  mlfs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mlfs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .pid_i        (pid_i),
    .level_i      (level_i),
    .resource_i   (resource_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pid_o    (out_pid_o),
    .quantum_o    (quantum_o),
    .status_o     (status_o),
    .moved_count_o(moved_count_o)
  );

endmodule

>>> src/mlfs_ram.sv
module mlfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mlfs_ctrl.sv
module mlfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mlfs_pkg::status_t sts_i,
  output mlfs_pkg::cmd_t    cmd_o
);

  mlfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlfs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.step  = mlfs_pkg::STEP_NONE;
    in_ready_o  = 1'b0;
    unique case (state_q)
      mlfs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = mlfs_pkg::STEP_LATCH;
          state_d    = mlfs_pkg::S_EXEC;
        end
      end
      mlfs_pkg::S_EXEC: begin
        cmd_o.step = mlfs_pkg::STEP_EXEC;
        state_d    = mlfs_pkg::S_DONE;
        if (sts_i.func == mlfs_pkg::FN_SEL && sts_i.any_ready) begin
          state_d = mlfs_pkg::S_SEL_WB;
        end else if (sts_i.func == mlfs_pkg::FN_UNB && !sts_i.blk_empty) begin
          state_d = mlfs_pkg::S_UNB_WB;
        end else if (sts_i.func == mlfs_pkg::FN_REL && !sts_i.blk_empty) begin
          state_d = mlfs_pkg::S_REL_WB;
        end
      end
      mlfs_pkg::S_SEL_WB: begin
        cmd_o.step = mlfs_pkg::STEP_SEL_WB;
        state_d    = mlfs_pkg::S_DONE;
      end
      mlfs_pkg::S_UNB_WB: begin
        cmd_o.step = mlfs_pkg::STEP_UNB_WB;
        state_d    = mlfs_pkg::S_DONE;
      end
      mlfs_pkg::S_REL_WB: begin
        cmd_o.step = mlfs_pkg::STEP_REL_WB;
        if (sts_i.rem_last) begin
          state_d = mlfs_pkg::S_DONE;
        end
      end
      mlfs_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.step = mlfs_pkg::STEP_LOAD;
          state_d    = mlfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mlfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> src/mlfs_dp.sv
module mlfs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mlfs_pkg::cmd_t                cmd_i,
  output mlfs_pkg::status_t             sts_o,
  input  logic                          cfg_valid_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [mlfs_pkg::Q_W-1:0]      cfg_data_i,
  input  logic [mlfs_pkg::FUNC_W-1:0]   func_i,
  input  logic [mlfs_pkg::PID_W-1:0]    pid_i,
  input  logic [mlfs_pkg::LVL_W-1:0]    level_i,
  input  logic [mlfs_pkg::RES_W-1:0]    resource_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mlfs_pkg::PID_W-1:0]    out_pid_o,
  output logic [mlfs_pkg::Q_W-1:0]      quantum_o,
  output logic [mlfs_pkg::ST_W-1:0]     status_o,
  output logic [mlfs_pkg::MV_W-1:0]     moved_count_o
);

  localparam int RA_W = mlfs_pkg::LVL_W + mlfs_pkg::PTR_W;

  logic [mlfs_pkg::FUNC_W-1:0] func_q;
  logic [mlfs_pkg::PID_W-1:0]  pid_q;
  logic [mlfs_pkg::LVL_W-1:0]  lvl_q;
  logic [mlfs_pkg::RES_W-1:0]  res_q;

  logic [mlfs_pkg::Q_W-1:0]    quant_q [mlfs_pkg::LEVELS];
  logic [mlfs_pkg::LVL_W-1:0]  plevel_q [mlfs_pkg::NPID];
  logic [mlfs_pkg::PTR_W-1:0]  rhead_q [mlfs_pkg::LEVELS];
  logic [mlfs_pkg::PTR_W-1:0]  rtail_q [mlfs_pkg::LEVELS];
  logic [mlfs_pkg::CNT_W-1:0]  rcnt_q [mlfs_pkg::LEVELS];
  logic [mlfs_pkg::PTR_W-1:0]  bhead_q, btail_q;
  logic [mlfs_pkg::CNT_W-1:0]  bcnt_q, rem_q;
  logic [mlfs_pkg::LVL_W-1:0]  sel_lv_q;

  logic [mlfs_pkg::PID_W-1:0]  o_pid_q;
  logic [mlfs_pkg::Q_W-1:0]    o_q_q;
  logic [mlfs_pkg::ST_W-1:0]   o_st_q;
  logic [mlfs_pkg::MV_W-1:0]   o_mv_q;

  logic                        out_valid_q;
  logic [mlfs_pkg::PID_W-1:0]  out_pid_q;
  logic [mlfs_pkg::Q_W-1:0]    out_q_q;
  logic [mlfs_pkg::ST_W-1:0]   out_st_q;
  logic [mlfs_pkg::MV_W-1:0]   out_mv_q;

  logic [mlfs_pkg::PID_W-1:0]  rrdata;
  logic [mlfs_pkg::BLK_W-1:0]  brdata;
  logic [mlfs_pkg::PID_W-1:0]  blk_pid;
  logic [mlfs_pkg::RES_W-1:0]  blk_res;
  logic [mlfs_pkg::PID_W-1:0]  ep;
  logic [mlfs_pkg::LVL_W-1:0]  plv;
  logic                        push_ok;
  logic                        any_ready;
  logic [mlfs_pkg::LVL_W-1:0]  fl;
  logic                        do_push;
  logic                        rel_match;
  logic [RA_W-1:0]             r_raddr, r_waddr;
  logic                        b_we;
  logic [mlfs_pkg::PTR_W-1:0]  b_waddr, b_raddr;
  logic [mlfs_pkg::BLK_W-1:0]  b_wdata;

  assign blk_pid = brdata[mlfs_pkg::BLK_W-1:mlfs_pkg::RES_W];
  assign blk_res = brdata[mlfs_pkg::RES_W-1:0];

  // The process whose level is looked up: the input pid, the pid just popped
  // from a ready queue, or the pid at the blocked queue head.
  always_comb begin
    case (cmd_i.step)
      mlfs_pkg::STEP_EXEC:   ep = pid_q;
      mlfs_pkg::STEP_SEL_WB: ep = rrdata;
      default:               ep = blk_pid;
    endcase
  end

  assign plv       = plevel_q[ep];
  assign push_ok   = rcnt_q[plv] != mlfs_pkg::CNT_W'(mlfs_pkg::MAX_PROCS);
  assign rel_match = blk_res == res_q;

  always_comb begin
    any_ready = 1'b1;
    if (rcnt_q[0] != '0) begin
      fl = 2'd0;
    end else if (rcnt_q[1] != '0) begin
      fl = 2'd1;
    end else if (rcnt_q[2] != '0) begin
      fl = 2'd2;
    end else begin
      fl        = 2'd3;
      any_ready = rcnt_q[3] != '0;
    end
  end

  always_comb begin
    do_push = 1'b0;
    case (cmd_i.step)
      mlfs_pkg::STEP_EXEC:   do_push = func_q == mlfs_pkg::FN_ENQ && push_ok;
      mlfs_pkg::STEP_UNB_WB: do_push = push_ok;
      mlfs_pkg::STEP_REL_WB: do_push = rel_match && push_ok;
      default:               do_push = 1'b0;
    endcase
  end

  assign r_raddr = {fl, rhead_q[fl]};
  assign r_waddr = {plv, rtail_q[plv]};

  assign b_we    = (cmd_i.step == mlfs_pkg::STEP_EXEC && func_q == mlfs_pkg::FN_BLK &&
                    bcnt_q != mlfs_pkg::CNT_W'(mlfs_pkg::MAX_PROCS)) ||
                   (cmd_i.step == mlfs_pkg::STEP_REL_WB && !do_push);
  assign b_waddr = btail_q;
  assign b_wdata = (cmd_i.step == mlfs_pkg::STEP_REL_WB) ? brdata : {pid_q, res_q};
  // During a release walk the next head is read while the current one is handled.
  assign b_raddr = (cmd_i.step == mlfs_pkg::STEP_REL_WB) ? mlfs_pkg::ptr_inc(bhead_q)
                                                         : bhead_q;

  mlfs_ram #(
    .WIDTH(mlfs_pkg::PID_W),
    .DEPTH(mlfs_pkg::LEVELS * mlfs_pkg::MAX_PROCS)
  ) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (do_push),
    .waddr_i(r_waddr),
    .wdata_i(ep),
    .raddr_i(r_raddr),
    .rdata_o(rrdata)
  );

  mlfs_ram #(
    .WIDTH(mlfs_pkg::BLK_W),
    .DEPTH(mlfs_pkg::MAX_PROCS)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .raddr_i(b_raddr),
    .rdata_o(brdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == mlfs_pkg::STEP_LATCH) begin
      func_q <= func_i;
      pid_q  <= pid_i;
      lvl_q  <= level_i;
      res_q  <= resource_i;
      o_pid_q <= '0;
      o_q_q   <= '0;
      o_st_q  <= mlfs_pkg::ST_OK;
      o_mv_q  <= '0;
    end
    if (cmd_i.step == mlfs_pkg::STEP_EXEC) begin
      sel_lv_q <= fl;
      rem_q    <= bcnt_q;
      case (func_q)
        mlfs_pkg::FN_ENQ: if (!push_ok) o_st_q <= mlfs_pkg::ST_FULL;
        mlfs_pkg::FN_SEL: if (!any_ready) o_st_q <= mlfs_pkg::ST_NONE;
        mlfs_pkg::FN_BLK: begin
          if (bcnt_q == mlfs_pkg::CNT_W'(mlfs_pkg::MAX_PROCS)) o_st_q <= mlfs_pkg::ST_FULL;
        end
        mlfs_pkg::FN_UNB, mlfs_pkg::FN_REL: begin
          if (bcnt_q == '0) o_st_q <= mlfs_pkg::ST_BEMPTY;
        end
        default: ;
      endcase
    end
    if (cmd_i.step == mlfs_pkg::STEP_SEL_WB) begin
      o_pid_q <= rrdata;
      o_q_q   <= quant_q[sel_lv_q];
    end
    if (cmd_i.step == mlfs_pkg::STEP_UNB_WB) begin
      if (push_ok) begin
        o_pid_q <= blk_pid;
      end else begin
        o_st_q <= mlfs_pkg::ST_FULL;
      end
    end
    if (cmd_i.step == mlfs_pkg::STEP_REL_WB) begin
      rem_q <= rem_q - 1'b1;
      if (do_push) begin
        o_mv_q <= o_mv_q + mlfs_pkg::MV_W'(1);
      end else if (rel_match) begin
        o_st_q <= mlfs_pkg::ST_FULL;
      end
    end
    if (cmd_i.step == mlfs_pkg::STEP_LOAD) begin
      out_pid_q <= o_pid_q;
      out_q_q   <= o_q_q;
      out_st_q  <= o_st_q;
      out_mv_q  <= o_mv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q[0]  <= 8'd1;
      quant_q[1]  <= 8'd2;
      quant_q[2]  <= 8'd4;
      quant_q[3]  <= 8'd8;
      for (int i = 0; i < mlfs_pkg::NPID; i++) begin
        plevel_q[i] <= '0;
      end
      for (int i = 0; i < mlfs_pkg::LEVELS; i++) begin
        rhead_q[i] <= '0;
        rtail_q[i] <= '0;
        rcnt_q[i]  <= '0;
      end
      bhead_q     <= '0;
      btail_q     <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        quant_q[cfg_index_i] <= cfg_data_i;
      end
      if (do_push) begin
        rtail_q[plv] <= mlfs_pkg::ptr_inc(rtail_q[plv]);
        rcnt_q[plv]  <= rcnt_q[plv] + 1'b1;
      end
      if (cmd_i.step == mlfs_pkg::STEP_EXEC && func_q == mlfs_pkg::FN_SEL && any_ready) begin
        rhead_q[fl] <= mlfs_pkg::ptr_inc(rhead_q[fl]);
        rcnt_q[fl]  <= rcnt_q[fl] - 1'b1;
      end
      if (cmd_i.step == mlfs_pkg::STEP_EXEC && func_q == mlfs_pkg::FN_SETLVL) begin
        plevel_q[pid_q] <= lvl_q;
      end
      if (cmd_i.step == mlfs_pkg::STEP_SEL_WB && plv != 2'd3) begin
        plevel_q[rrdata] <= plv + 1'b1;
      end
      if (b_we) begin
        btail_q <= mlfs_pkg::ptr_inc(btail_q);
      end
      if (cmd_i.step == mlfs_pkg::STEP_EXEC && b_we) begin
        bcnt_q <= bcnt_q + 1'b1;
      end
      if ((cmd_i.step == mlfs_pkg::STEP_UNB_WB && push_ok) ||
          cmd_i.step == mlfs_pkg::STEP_REL_WB) begin
        bhead_q <= mlfs_pkg::ptr_inc(bhead_q);
      end
      if (do_push && (cmd_i.step == mlfs_pkg::STEP_UNB_WB ||
                      cmd_i.step == mlfs_pkg::STEP_REL_WB)) begin
        bcnt_q <= bcnt_q - 1'b1;
      end
      if (cmd_i.step == mlfs_pkg::STEP_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.any_ready = any_ready;
  assign sts_o.blk_empty = bcnt_q == '0;
  assign sts_o.rem_last  = rem_q == mlfs_pkg::CNT_W'(1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_pid_o     = out_pid_q;
  assign quantum_o     = out_q_q;
  assign status_o      = out_st_q;
  assign moved_count_o = out_mv_q;

  a_bcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= mlfs_pkg::CNT_W'(mlfs_pkg::MAX_PROCS))
    else $error("blocked queue count overflow");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step == mlfs_pkg::STEP_LOAD |=> out_valid_q)
    else $error("result not presented after load");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step == mlfs_pkg::STEP_LOAD |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step == mlfs_pkg::STEP_REL_WB |-> rem_q != '0)
    else $error("release walk ran past the queue length");

endmodule
